/* hw/rtl/apc_pkg.sv */
// Package for the auto-ranging pedal to controller map.
// Holds field widths, codes and the sequencer state type; no dependencies.
`default_nettype none

package apc_pkg;

    localparam int SAMPLE_W   = 10;           // pedal reading and range registers
    localparam int OUT_W      = 7;            // mapped controller value
    localparam int CC_W       = 4;            // controller number
    localparam int SW_W       = 2;            // bank switch position
    localparam int NUM_W      = SAMPLE_W + OUT_W;   // (sample - low) * 127
    localparam int QUOT_BITS  = OUT_W;        // quotient is always below 128
    localparam int CNT_W      = $clog2(QUOT_BITS);

    localparam logic [SAMPLE_W-1:0] RANGE_LOW_RST  = SAMPLE_W'(400);
    localparam logic [SAMPLE_W-1:0] RANGE_HIGH_RST = SAMPLE_W'(500);
    localparam logic [CC_W-1:0]     BASE_CC        = CC_W'(4);

    // configuration register indexes
    localparam logic CFG_RANGE_LOW  = 1'b0;
    localparam logic CFG_RANGE_HIGH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } apc_state_t;

endpackage

`default_nettype wire

/* hw/rtl/autorange_pedal_to_cc.sv */
// Auto-ranging expression pedal to controller map, top level.
// Depends on apc_pkg (widths, register indexes, sequencer states).
//
// Usage:
//   Input beats (s_axis_*) carry one pedal sample with its connect line and the
//   bank switch position. A beat produces at most one output beat (m_axis_*):
//   a controller number and a 0..127 value, sent only when the value changes.
//   The range registers are written through cfg_we/cfg_addr/cfg_wdata; the
//   user must write them only while the block is idle; the block does not enforce it.
// Sequencing: s_axis_tready is high only while the sequencer is idle, so a
//   new beat waits until the last is through. A pedal beyond NUM_PEDALS is
//   dropped in idle, a disconnected or unchanged sample ends after evaluate, a
//   zero span skips the divide, and a mapped beat runs evaluate, prepare, 7
//   restoring-divide steps on one shared subtractor, finish.
// Reset (aresetn low, synchronous): pedals disconnected, tracked ranges
//   400..500, previous sample and value 0, range registers 400 and 500.
// Stall: one output register parts the sides; a new beat is accepted while a
//   result waits, but the next result holds the sequencer in its finish step
//   until m_axis_tready takes the waiting beat.
`default_nettype none

module autorange_pedal_to_cc
    import apc_pkg::*;
#(
    parameter int NUM_PEDALS = 2
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                cfg_we,
    input  wire logic                cfg_addr,
    input  wire logic [SAMPLE_W-1:0] cfg_wdata,

    input  wire logic                s_axis_tvalid,
    output      logic                s_axis_tready,
    input  wire logic [15:0]         s_axis_tdata,   // [9:0] sample_value
    input  wire logic [3:0]          s_axis_tuser,   // [0] pedal_index, [1] pedal_present,
                                                     // [3:2] bank_switch

    output      logic                m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output      logic [7:0]          m_axis_tdata,   // [6:0] control_value
    output      logic [CC_W-1:0]     m_axis_tuser    // [3:0] control_number
);

    localparam int IDX_W = (NUM_PEDALS > 1) ? $clog2(NUM_PEDALS) : 1;

    apc_state_t state_reg, state_next;

    logic [SAMPLE_W-1:0] cfg_low_reg, cfg_high_reg;

    // per-pedal tracking state
    logic                present_reg     [NUM_PEDALS];
    logic [SAMPLE_W-1:0] low_reg         [NUM_PEDALS];
    logic [SAMPLE_W-1:0] high_reg        [NUM_PEDALS];
    logic [SAMPLE_W-1:0] prev_sample_reg [NUM_PEDALS];
    logic [OUT_W-1:0]    prev_out_reg    [NUM_PEDALS];

    // captured input beat
    logic                pidx_reg;
    logic                pres_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SW_W-1:0]     sw_reg;

    // divider
    logic [NUM_W-1:0]    rem_reg;
    logic [SAMPLE_W-1:0] span_reg;
    logic [QUOT_BITS-1:0] q_reg;
    logic [CNT_W-1:0]    cnt_reg;

    // output register
    logic                m_valid_reg;
    logic [OUT_W-1:0]    m_val_reg;
    logic [CC_W-1:0]     m_cc_reg;

    logic [IDX_W-1:0]    idx;
    logic                in_beat;
    logic                in_range;
    logic                connect;
    logic                active;
    logic [SAMPLE_W-1:0] base_lo, base_hi, wid_lo, wid_hi;
    logic [SAMPLE_W-1:0] diff, span;
    logic [NUM_W-1:0]    num;
    logic [NUM_W-1:0]    divisor;
    logic [NUM_W:0]      trial;
    logic                fits;
    logic                out_free;
    logic                differs;
    logic                out_load;

    assign idx      = IDX_W'(pidx_reg);
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign in_range = int'(s_axis_tuser[0]) < NUM_PEDALS;

    // evaluate step: connect handling and range widening
    assign connect = pres_reg && !present_reg[idx];
    assign active  = pres_reg && (sample_reg != prev_sample_reg[idx]);
    assign base_lo = connect ? cfg_low_reg  : low_reg[idx];
    assign base_hi = connect ? cfg_high_reg : high_reg[idx];
    assign wid_lo  = (sample_reg < base_lo) ? sample_reg : base_lo;
    assign wid_hi  = (sample_reg > base_hi) ? sample_reg : base_hi;

    // prepare step: numerator (s - lo) * 127 and span
    assign diff = sample_reg - low_reg[idx];
    assign num  = {diff, {OUT_W{1'b0}}} - {{OUT_W{1'b0}}, diff};
    assign span = high_reg[idx] - low_reg[idx];

    // shared restoring-divide step
    assign divisor = NUM_W'(span_reg) << cnt_reg;
    assign trial   = {1'b0, rem_reg} - {1'b0, divisor};
    assign fits    = !trial[NUM_W];

    assign out_free = !m_valid_reg || m_axis_tready;
    assign differs  = q_reg != prev_out_reg[idx];

    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_beat && in_range) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = active ? ST_PREP : ST_IDLE;
            end
            ST_PREP: begin
                state_next = (span == '0) ? ST_FINISH : ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!differs) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_low_reg  <= RANGE_LOW_RST;
            cfg_high_reg <= RANGE_HIGH_RST;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_RANGE_LOW) begin
                cfg_low_reg <= cfg_wdata;
            end
            if (cfg_addr == CFG_RANGE_HIGH) begin
                cfg_high_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_PEDALS; i++) begin
                present_reg[i]     <= 1'b0;
                low_reg[i]         <= RANGE_LOW_RST;
                high_reg[i]        <= RANGE_HIGH_RST;
                prev_sample_reg[i] <= '0;
                prev_out_reg[i]    <= '0;
            end
        end else begin
            if (state_reg == ST_EVAL) begin
                present_reg[idx] <= pres_reg;
                if (active) begin
                    low_reg[idx]         <= wid_lo;
                    high_reg[idx]        <= wid_hi;
                    prev_sample_reg[idx] <= sample_reg;
                end else if (connect) begin
                    low_reg[idx]  <= cfg_low_reg;
                    high_reg[idx] <= cfg_high_reg;
                end
            end
            if (out_load) begin
                prev_out_reg[idx] <= q_reg;
            end
        end
    end

    // beat capture and divider datapath
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            pidx_reg   <= s_axis_tuser[0];
            pres_reg   <= s_axis_tuser[1];
            sw_reg     <= s_axis_tuser[3:2];
            sample_reg <= s_axis_tdata[SAMPLE_W-1:0];
        end
        if (state_reg == ST_PREP) begin
            rem_reg  <= num;
            span_reg <= span;
            q_reg    <= '0;
            cnt_reg  <= CNT_W'(QUOT_BITS - 1);
        end else if (state_reg == ST_DIV) begin
            if (fits) begin
                rem_reg <= trial[NUM_W-1:0];
            end
            q_reg   <= {q_reg[QUOT_BITS-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_val_reg <= q_reg;
            m_cc_reg  <= BASE_CC + CC_W'(pidx_reg) + {1'b0, sw_reg, 1'b0};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, m_val_reg};
    assign m_axis_tuser  = m_cc_reg;

    // remainder stays below twice the current divisor step
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |->
            {1'b0, rem_reg} < ((NUM_W + 1)'(span_reg) << (cnt_reg + 1'b1)))
        else $error("divider remainder out of bound");

    // widened range always contains the sample being mapped
    a_range_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PREP |->
            (low_reg[idx] <= sample_reg) && (sample_reg <= high_reg[idx]))
        else $error("tracked range does not contain sample");

    // sequencer leaves idle only on an accepted beat
    a_busy_on_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("left idle without an input beat");

    // a result appears only out of the finish step
    a_out_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("output beat not from finish step");

endmodule

`default_nettype wire
